@@ design/fsc_pkg.sv @@
// Shared types, constants and arithmetic helpers of the fisheye source-coordinate unit.
// Used by every cell module, the top level and the checker.
package fsc_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int MAX_DIM      = 4096;
   localparam int DIM_W        = 13;
   localparam int CRD_W        = 12;
   localparam int STR_W        = 15;
   localparam int STRENGTH_MAX = 24575;

   localparam int OFS_W  = 15;
   localparam int SQR_W  = 27;
   localparam int SUM_W  = SQR_W + 1;
   localparam int M_W    = 2 * DIM_W;
   localparam int NDIV   = 2 * FRAC_BITS;
   localparam int QUO_W  = NDIV;
   localparam int NSQ    = QUO_W / 2;
   localparam int RES_W  = QUO_W + 2;
   localparam int RN_W   = NSQ;
   localparam int PROD_W = STR_W + RN_W;
   localparam int ANG_W  = 34;
   localparam int NCOR   = 30;
   localparam int SIN_W  = 31;
   localparam int DEN_W  = 33;
   localparam int NUM_W  = RN_W + SIN_W;
   localparam int NQ     = FRAC_BITS + 2;
   localparam int QW     = DEN_W + NQ;
   localparam int SC_W   = NQ;
   localparam int PX_W   = OFS_W + SC_W + 1;
   localparam int FIN_W  = 36;

   localparam logic [DIM_W-1:0] WIDTH_RESET    = DIM_W'(640);
   localparam logic [DIM_W-1:0] HEIGHT_RESET   = DIM_W'(480);
   localparam logic [STR_W-1:0] STRENGTH_RESET = STR_W'(16384);

   localparam logic [31:0]            PI_Q30      = 32'd3373259426;
   localparam logic [31:0]            HALF_PI_Q30 = 32'd1686629713;
   localparam logic signed [ANG_W-1:0] GAIN_Q30   = 34'sh026DD3B6A;
   localparam logic [SC_W-1:0]         SCALE_MAX  = SC_W'(2 << FRAC_BITS);

   localparam logic [31:0] ATAN_Q30 [NCOR] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
      32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
      32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
      32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
      32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
   };

   typedef enum logic [1:0] {
      CSR_WIDTH,
      CSR_HEIGHT,
      CSR_STRENGTH
   } csr_index_type;

   typedef struct packed {
      logic                    vld;
      logic                    nz;
      logic                    sat;
      logic [DIM_W-1:0]        w;
      logic [DIM_W-1:0]        h;
      logic signed [OFS_W-1:0] dx2;
      logic signed [OFS_W-1:0] dy2;
      logic [STR_W-1:0]        s;
      logic [RN_W-1:0]         rn;
   } tag_type;

   typedef struct packed {
      logic signed [ANG_W-1:0] x;
      logic signed [ANG_W-1:0] y;
      logic signed [ANG_W-1:0] z;
   } rot_type;

   // Angles above a quarter turn are mirrored so the rotation converges.
   function automatic rot_type cordic_init(logic [31:0] a);
      rot_type r;
      r.x = GAIN_Q30;
      r.y = '0;
      if (a > HALF_PI_Q30) begin
         r.z = $signed({2'b00, PI_Q30 - a});
      end else begin
         r.z = $signed({2'b00, a});
      end
      return r;
   endfunction

   function automatic rot_type cordic_step(rot_type r, int step);
      rot_type                 o;
      logic signed [ANG_W-1:0] a;
      a = $signed({2'b00, ATAN_Q30[step]});
      if (!r.z[ANG_W-1]) begin
         o.x = r.x - (r.y >>> step);
         o.y = r.y + (r.x >>> step);
         o.z = r.z - a;
      end else begin
         o.x = r.x + (r.y >>> step);
         o.y = r.y - (r.x >>> step);
         o.z = r.z + a;
      end
      return o;
   endfunction

endpackage

@@ design/fsc_div_cell.sv @@
// One restoring-division step that forms a bit of the normalized squared radius.
// Depends on fsc_pkg.
module fsc_div_cell
   import fsc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  tag_type          tag_i,
   input  logic [M_W-1:0]   m_i,
   input  logic [M_W-1:0]   rem_i,
   input  logic [QUO_W-1:0] quo_i,
   output tag_type          tag_o,
   output logic [M_W-1:0]   m_o,
   output logic [M_W-1:0]   rem_o,
   output logic [QUO_W-1:0] quo_o
);

   tag_type          tag_ff;
   logic [M_W-1:0]   m_ff;
   logic [M_W-1:0]   rem_ff;
   logic [M_W-1:0]   rem_in;
   logic [QUO_W-1:0] quo_ff;
   logic [QUO_W-1:0] quo_in;
   logic [M_W:0]     sh;
   logic [M_W:0]     diff;
   logic             ge;

   assign sh     = {rem_i, 1'b0};
   assign diff   = sh - {1'b0, m_i};
   assign ge     = sh >= {1'b0, m_i};
   assign rem_in = ge ? diff[M_W-1:0] : sh[M_W-1:0];
   assign quo_in = {quo_i[QUO_W-2:0], ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (adv) begin
         tag_ff <= tag_i;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_ff   <= m_i;
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign tag_o = tag_ff;
   assign m_o   = m_ff;
   assign rem_o = rem_ff;
   assign quo_o = quo_ff;

endmodule

@@ design/fsc_sqrt_cell.sv @@
// One step of the digit-by-digit integer square root of the normalized squared radius.
// Depends on fsc_pkg.
module fsc_sqrt_cell
   import fsc_pkg::*;
#(
   parameter int STEP = 0
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  tag_type          tag_i,
   input  logic [QUO_W-1:0] v_i,
   input  logic [RES_W-1:0] res_i,
   output tag_type          tag_o,
   output logic [QUO_W-1:0] v_o,
   output logic [RES_W-1:0] res_o
);

   localparam logic [RES_W-1:0] BIT = RES_W'(1) << (2 * (NSQ - 1 - STEP));

   tag_type          tag_ff;
   logic [QUO_W-1:0] v_ff;
   logic [QUO_W-1:0] v_in;
   logic [RES_W-1:0] res_ff;
   logic [RES_W-1:0] res_in;
   logic [RES_W-1:0] trial;
   logic [RES_W-1:0] diff;
   logic             ge;

   assign trial  = res_i + BIT;
   assign ge     = RES_W'(v_i) >= trial;
   assign diff   = RES_W'(v_i) - trial;
   assign v_in   = ge ? diff[QUO_W-1:0] : v_i;
   assign res_in = ge ? ((res_i >> 1) + BIT) : (res_i >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (adv) begin
         tag_ff <= tag_i;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         v_ff   <= v_in;
         res_ff <= res_in;
      end
   end

   assign tag_o = tag_ff;
   assign v_o   = v_ff;
   assign res_o = res_ff;

endmodule

@@ design/fsc_cordic_cell.sv @@
// One CORDIC rotation step, applied to the strength sine and the pixel sine in parallel.
// Depends on fsc_pkg.
module fsc_cordic_cell
   import fsc_pkg::*;
#(
   parameter int STEP = 0
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  tag_type     tag_i,
   input  rot_type     rot_s_i,
   input  rot_type     rot_t_i,
   input  logic [31:0] theta_i,
   output tag_type     tag_o,
   output rot_type     rot_s_o,
   output rot_type     rot_t_o,
   output logic [31:0] theta_o
);

   tag_type     tag_ff;
   rot_type     rot_s_ff;
   rot_type     rot_t_ff;
   logic [31:0] theta_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (adv) begin
         tag_ff <= tag_i;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rot_s_ff <= cordic_step(rot_s_i, STEP);
         rot_t_ff <= cordic_step(rot_t_i, STEP);
         theta_ff <= theta_i;
      end
   end

   assign tag_o   = tag_ff;
   assign rot_s_o = rot_s_ff;
   assign rot_t_o = rot_t_ff;
   assign theta_o = theta_ff;

endmodule

@@ design/fsc_qdiv_cell.sv @@
// One restoring-division step of the radial scale factor, most significant bit first.
// Depends on fsc_pkg.
module fsc_qdiv_cell
   import fsc_pkg::*;
#(
   parameter int STEP = 0
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  tag_type          tag_i,
   input  logic [NUM_W-1:0] rem_i,
   input  logic [DEN_W-1:0] d_i,
   input  logic [NQ-1:0]    q_i,
   output tag_type          tag_o,
   output logic [NUM_W-1:0] rem_o,
   output logic [DEN_W-1:0] d_o,
   output logic [NQ-1:0]    q_o
);

   localparam int SH = NQ - 1 - STEP;

   tag_type          tag_ff;
   logic [NUM_W-1:0] rem_ff;
   logic [NUM_W-1:0] rem_in;
   logic [DEN_W-1:0] d_ff;
   logic [NQ-1:0]    q_ff;
   logic [NQ-1:0]    q_in;
   logic [QW-1:0]    dsh;
   logic [QW-1:0]    diff;
   logic             ge;

   assign dsh    = QW'(d_i) << SH;
   assign ge     = QW'(rem_i) >= dsh;
   assign diff   = QW'(rem_i) - dsh;
   assign rem_in = ge ? diff[NUM_W-1:0] : rem_i;
   assign q_in   = {q_i[NQ-2:0], ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (adv) begin
         tag_ff <= tag_i;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff <= rem_in;
         d_ff   <= d_i;
         q_ff   <= q_in;
      end
   end

   assign tag_o = tag_ff;
   assign rem_o = rem_ff;
   assign d_o   = d_ff;
   assign q_o   = q_ff;

endmodule

@@ design/fisheye_source_coordinate_unit.sv @@
// Fisheye source-coordinate unit: maps a destination pixel to the source pixel of an
// inverse fisheye warp. Depends on fsc_pkg and the div, sqrt, cordic and qdiv cells.
// A beat travels from the accepting edge to rsp_valid through the chains of cells
// (32 division, 16 square-root, 30 CORDIC and 18 scale-division cells plus edge stages).
// Throughput is one beat per cycle; the whole chain halts only while a result waits.
// Synchronous reset clears all valid flags and loads width 640, height 480, strength 16384.
module fisheye_source_coordinate_unit
   import fsc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [CRD_W-1:0] req_dest_x,
   input  logic [CRD_W-1:0] req_dest_y,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [CRD_W-1:0] rsp_src_x,
   output logic [CRD_W-1:0] rsp_src_y,
   input  logic             csr_write,
   input  logic [1:0]       csr_index,
   input  logic [STR_W-1:0] csr_wdata
);

   function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v);
      if (v == '0) begin
         return DIM_W'(1);
      end
      if (v > DIM_W'(MAX_DIM)) begin
         return DIM_W'(MAX_DIM);
      end
      return v;
   endfunction

   function automatic logic [CRD_W-1:0] map_coord(logic [DIM_W-1:0] dim,
                                                  logic signed [PX_W-1:0] p);
      logic signed [FIN_W-1:0] num;
      logic signed [FIN_W-1:0] mag;
      logic signed [FIN_W-1:0] v;
      logic signed [FIN_W-1:0] lim;
      num = $signed({{(FIN_W-DIM_W-FRAC_BITS){1'b0}}, dim, {FRAC_BITS{1'b0}}})
            + FIN_W'(p);
      mag = (num < 0) ? -num : num;
      v   = mag >>> (FRAC_BITS + 1);
      if (num < 0) begin
         v = -v;
      end
      lim = $signed(FIN_W'(dim)) - 1;
      if (v < 0) begin
         v = '0;
      end
      if (v > lim) begin
         v = lim;
      end
      return v[CRD_W-1:0];
   endfunction

   logic             adv;
   logic [DIM_W-1:0] width_ff;
   logic [DIM_W-1:0] height_ff;
   logic [STR_W-1:0] strength_ff;

   logic             rsp_valid_ff;
   logic [CRD_W-1:0] rsp_src_x_ff;
   logic [CRD_W-1:0] rsp_src_y_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_src_x = rsp_src_x_ff;
   assign rsp_src_y = rsp_src_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WIDTH_RESET;
         height_ff   <= HEIGHT_RESET;
         strength_ff <= STRENGTH_RESET;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_WIDTH: begin
               width_ff <= csr_wdata[DIM_W-1:0];
            end
            CSR_HEIGHT: begin
               height_ff <= csr_wdata[DIM_W-1:0];
            end
            CSR_STRENGTH: begin
               strength_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // Entry stage: clamped registers and doubled offsets from the center.
   tag_type          tag_a_in;
   tag_type          tag_a_ff;
   logic [DIM_W-1:0] w_cl;
   logic [DIM_W-1:0] h_cl;
   logic [STR_W-1:0] s_cl;

   assign w_cl = clamp_dim(width_ff);
   assign h_cl = clamp_dim(height_ff);

   always_comb begin
      if (strength_ff == '0) begin
         s_cl = STR_W'(1);
      end else if (strength_ff > STR_W'(STRENGTH_MAX)) begin
         s_cl = STR_W'(STRENGTH_MAX);
      end else begin
         s_cl = strength_ff;
      end
      tag_a_in     = '0;
      tag_a_in.vld = req_valid;
      tag_a_in.w   = w_cl;
      tag_a_in.h   = h_cl;
      tag_a_in.s   = s_cl;
      tag_a_in.dx2 = $signed({2'b00, req_dest_x, 1'b0}) - $signed({2'b00, w_cl});
      tag_a_in.dy2 = $signed({2'b00, req_dest_y, 1'b0}) - $signed({2'b00, h_cl});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_a_ff <= '0;
      end else if (adv) begin
         tag_a_ff <= tag_a_in;
      end
   end

   // Squares of the offsets and of the dimensions.
   tag_type                   tag_b_ff;
   logic [SQR_W-1:0]          sqx_ff;
   logic [SQR_W-1:0]          sqy_ff;
   logic [M_W-1:0]            w2_ff;
   logic [M_W-1:0]            h2_ff;
   logic signed [2*OFS_W-1:0] sqx_full;
   logic signed [2*OFS_W-1:0] sqy_full;
   logic [M_W-1:0]            w2;
   logic [M_W-1:0]            h2;

   assign sqx_full = tag_a_ff.dx2 * tag_a_ff.dx2;
   assign sqy_full = tag_a_ff.dy2 * tag_a_ff.dy2;
   assign w2       = tag_a_ff.w * tag_a_ff.w;
   assign h2       = tag_a_ff.h * tag_a_ff.h;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_b_ff <= '0;
      end else if (adv) begin
         tag_b_ff <= tag_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sqx_ff <= sqx_full[SQR_W-1:0];
         sqy_ff <= sqy_full[SQR_W-1:0];
         w2_ff  <= w2;
         h2_ff  <= h2;
      end
   end

   // Squared radius, limited to the corner radius.
   tag_type          tag_c_in;
   tag_type          tag_c_ff;
   logic [SUM_W-1:0] s_sum;
   logic [M_W-1:0]   m_sum;
   logic [M_W-1:0]   m_c_ff;
   logic [M_W-1:0]   rem_c_ff;

   assign s_sum = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign m_sum = w2_ff + h2_ff;

   always_comb begin
      tag_c_in    = tag_b_ff;
      tag_c_in.nz = s_sum != '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_c_ff <= '0;
      end else if (adv) begin
         tag_c_ff <= tag_c_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_c_ff   <= m_sum;
         rem_c_ff <= (s_sum > SUM_W'(m_sum)) ? m_sum : s_sum[M_W-1:0];
      end
   end

   // Normalized squared radius, one quotient bit per cell.
   tag_type          div_tag [NDIV+1];
   logic [M_W-1:0]   div_m   [NDIV+1];
   logic [M_W-1:0]   div_rem [NDIV+1];
   logic [QUO_W-1:0] div_quo [NDIV+1];

   assign div_tag[0] = tag_c_ff;
   assign div_m[0]   = m_c_ff;
   assign div_rem[0] = rem_c_ff;
   assign div_quo[0] = '0;

   for (genvar g = 0; g < NDIV; g++) begin : g_div
      fsc_div_cell u_div (
         .clock (clock),
         .reset (reset),
         .adv   (adv),
         .tag_i (div_tag[g]),
         .m_i   (div_m[g]),
         .rem_i (div_rem[g]),
         .quo_i (div_quo[g]),
         .tag_o (div_tag[g+1]),
         .m_o   (div_m[g+1]),
         .rem_o (div_rem[g+1]),
         .quo_o (div_quo[g+1])
      );
   end

   // Normalized radius.
   tag_type          sq_tag [NSQ+1];
   logic [QUO_W-1:0] sq_v   [NSQ+1];
   logic [RES_W-1:0] sq_res [NSQ+1];

   assign sq_tag[0] = div_tag[NDIV];
   assign sq_v[0]   = div_quo[NDIV];
   assign sq_res[0] = '0;

   for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
      fsc_sqrt_cell #(
         .STEP (g)
      ) u_sqrt (
         .clock (clock),
         .reset (reset),
         .adv   (adv),
         .tag_i (sq_tag[g]),
         .v_i   (sq_v[g]),
         .res_i (sq_res[g]),
         .tag_o (sq_tag[g+1]),
         .v_o   (sq_v[g+1]),
         .res_o (sq_res[g+1])
      );
   end

   // Strength times radius.
   tag_type           tag_p_in;
   tag_type           tag_p_ff;
   logic [PROD_W-1:0] prod;
   logic [PROD_W-1:0] prod_ff;

   always_comb begin
      tag_p_in    = sq_tag[NSQ];
      tag_p_in.rn = sq_res[NSQ][RN_W-1:0];
   end

   assign prod = tag_p_in.s * tag_p_in.rn;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_p_ff <= '0;
      end else if (adv) begin
         tag_p_ff <= tag_p_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod;
      end
   end

   // Rotation start points for both sines.
   tag_type     tag_i_ff;
   rot_type     rot_s_ff;
   rot_type     rot_t_ff;
   logic [31:0] theta;
   logic [31:0] theta_ff;
   logic [31:0] s30;

   assign theta = 32'(prod_ff) << (17 - FRAC_BITS);
   assign s30   = 32'(tag_p_ff.s) << 17;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_i_ff <= '0;
      end else if (adv) begin
         tag_i_ff <= tag_p_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rot_s_ff <= cordic_init(s30);
         rot_t_ff <= cordic_init(theta);
         theta_ff <= theta;
      end
   end

   tag_type     cor_tag [NCOR+1];
   rot_type     cor_s   [NCOR+1];
   rot_type     cor_t   [NCOR+1];
   logic [31:0] cor_th  [NCOR+1];

   assign cor_tag[0] = tag_i_ff;
   assign cor_s[0]   = rot_s_ff;
   assign cor_t[0]   = rot_t_ff;
   assign cor_th[0]  = theta_ff;

   for (genvar g = 0; g < NCOR; g++) begin : g_cordic
      fsc_cordic_cell #(
         .STEP (g)
      ) u_cordic (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .tag_i   (cor_tag[g]),
         .rot_s_i (cor_s[g]),
         .rot_t_i (cor_t[g]),
         .theta_i (cor_th[g]),
         .tag_o   (cor_tag[g+1]),
         .rot_s_o (cor_s[g+1]),
         .rot_t_o (cor_t[g+1]),
         .theta_o (cor_th[g+1])
      );
   end

   // A sine that is not positive falls back to the angle itself.
   tag_type                 tag_e_in;
   tag_type                 tag_e_ff;
   logic signed [ANG_W-1:0] sin_s;
   logic signed [ANG_W-1:0] sin_t;
   logic signed [ANG_W-1:0] den;
   logic [SIN_W-1:0]        ss_ff;
   logic [DEN_W-1:0]        d_e_ff;

   assign sin_s = cor_s[NCOR].y;
   assign sin_t = cor_t[NCOR].y;
   assign den   = (sin_t <= 0) ? $signed({2'b00, cor_th[NCOR]}) : sin_t;

   always_comb begin
      tag_e_in    = cor_tag[NCOR];
      tag_e_in.nz = cor_tag[NCOR].nz && (den > 0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_e_ff <= '0;
      end else if (adv) begin
         tag_e_ff <= tag_e_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ss_ff  <= sin_s[ANG_W-1] ? '0 : sin_s[SIN_W-1:0];
         d_e_ff <= den[DEN_W-1:0];
      end
   end

   // Numerator of the scale factor.
   tag_type          tag_n_ff;
   logic [NUM_W-1:0] num;
   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] d_n_ff;

   assign num = ss_ff * tag_e_ff.rn;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_n_ff <= '0;
      end else if (adv) begin
         tag_n_ff <= tag_e_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         num_ff <= num;
         d_n_ff <= d_e_ff;
      end
   end

   // A quotient beyond the division width saturates anyway.
   tag_type          tag_o_in;
   tag_type          tag_o_ff;
   logic [NUM_W-1:0] rem_o_ff;
   logic [DEN_W-1:0] d_o_ff;

   always_comb begin
      tag_o_in     = tag_n_ff;
      tag_o_in.sat = (QW'(d_n_ff) << NQ) <= QW'(num_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_o_ff <= '0;
      end else if (adv) begin
         tag_o_ff <= tag_o_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_o_ff <= num_ff;
         d_o_ff   <= d_n_ff;
      end
   end

   tag_type          qd_tag [NQ+1];
   logic [NUM_W-1:0] qd_rem [NQ+1];
   logic [DEN_W-1:0] qd_d   [NQ+1];
   logic [NQ-1:0]    qd_q   [NQ+1];

   assign qd_tag[0] = tag_o_ff;
   assign qd_rem[0] = rem_o_ff;
   assign qd_d[0]   = d_o_ff;
   assign qd_q[0]   = '0;

   for (genvar g = 0; g < NQ; g++) begin : g_qdiv
      fsc_qdiv_cell #(
         .STEP (g)
      ) u_qdiv (
         .clock (clock),
         .reset (reset),
         .adv   (adv),
         .tag_i (qd_tag[g]),
         .rem_i (qd_rem[g]),
         .d_i   (qd_d[g]),
         .q_i   (qd_q[g]),
         .tag_o (qd_tag[g+1]),
         .rem_o (qd_rem[g+1]),
         .d_o   (qd_d[g+1]),
         .q_o   (qd_q[g+1])
      );
   end

   // Saturated scale applied to both offsets.
   tag_type                tag_k_ff;
   tag_type                tag_q;
   logic [SC_W-1:0]        scale;
   logic signed [PX_W-1:0] px;
   logic signed [PX_W-1:0] py;
   logic signed [PX_W-1:0] px_ff;
   logic signed [PX_W-1:0] py_ff;

   assign tag_q = qd_tag[NQ];

   always_comb begin
      if (!tag_q.nz) begin
         scale = '0;
      end else if (tag_q.sat || (qd_q[NQ] > SCALE_MAX)) begin
         scale = SCALE_MAX;
      end else begin
         scale = qd_q[NQ];
      end
   end

   assign px = tag_q.dx2 * $signed({1'b0, scale});
   assign py = tag_q.dy2 * $signed({1'b0, scale});

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_k_ff <= '0;
      end else if (adv) begin
         tag_k_ff <= tag_q;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff <= px;
         py_ff <= py;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= tag_k_ff.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_src_x_ff <= map_coord(tag_k_ff.w, px_ff);
         rsp_src_y_ff <= map_coord(tag_k_ff.h, py_ff);
      end
   end

endmodule

@@ design/fsc_checker.sv @@
// Port-level checks of the fisheye source-coordinate unit, bound to the top level.
// Depends on fsc_pkg and fisheye_source_coordinate_unit.
module fsc_checker
   import fsc_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [CRD_W-1:0] rsp_src_x,
   input logic [CRD_W-1:0] rsp_src_y
);

   // The input side halts only while a finished beat waits at the output.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without a waiting result beat");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_src_x) && $stable(rsp_src_y)))
      else $error("stalled result beat changed");

endmodule

bind fisheye_source_coordinate_unit fsc_checker u_fsc_checker (.*);
